// ===== src/hole_list_fit_allocator_macros.svh =====
// Assertion macros shared by the hole list allocator modules.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef HOLE_LIST_FIT_ALLOCATOR_MACROS_SVH
`define HOLE_LIST_FIT_ALLOCATOR_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define HLFA_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// The consequence holds in the same cycle as the trigger.
`define HLFA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequence holds in the cycle after the trigger.
`define HLFA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/hlfa_pkg.sv =====
// Shared types, field widths and codes for the hole list fit allocator.
// Used by the channel interfaces and every module of the block; no dependencies.
`timescale 1ns / 1ps

package hlfa_pkg;

   // Default number of holes the table can hold.
   localparam int HLFA_TABLE_DEPTH = 64;

   // Field widths of the request and response channels.
   localparam int MODE_W      = 2;
   localparam int SIZE_W      = 32;
   localparam int INDEX_IN_W  = 6;
   localparam int STATUS_W    = 2;
   localparam int FOUND_W     = 6;
   localparam int COUNT_OUT_W = 7;
   localparam int POLICY_W    = 2;

   // Register port geometry: one 32-bit register per word.
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int REG_IDX_W   = CSR_ADDR_W - 2;

   typedef logic [REG_IDX_W-1:0] reg_idx_type;
   localparam reg_idx_type REG_FIT_POLICY = '0;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD    = 2'd0,
      MODE_FIND   = 2'd1,
      MODE_PEEK   = 2'd2,
      MODE_DELETE = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_FIT    = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_BAD_INDEX = 2'd3
   } status_type;

   // Policy code 3 selects no placement rule: adds are ignored.
   typedef enum logic [POLICY_W-1:0] {
      POLICY_FIRST = 2'd0,
      POLICY_BEST  = 2'd1,
      POLICY_WORST = 2'd2,
      POLICY_NONE  = 2'd3
   } policy_type;

   // One stored hole.
   typedef struct packed {
      logic [SIZE_W-1:0] hole_size;
      logic [SIZE_W-1:0] hole_offset;
   } entry_type;

   // Datapath commands.
   typedef enum logic [2:0] {
      PTR_HOLD  = 3'd0,
      PTR_ZERO  = 3'd1,
      PTR_INDEX = 3'd2,
      PTR_OUTER = 3'd3,
      PTR_INC   = 3'd4,
      PTR_DEC   = 3'd5
   } ptr_op_type;

   typedef enum logic [1:0] {
      RD_PTR    = 2'd0,
      RD_PTR_M1 = 2'd1,
      RD_PTR_P1 = 2'd2,
      RD_OUTER  = 2'd3
   } rd_src_type;

   typedef enum logic [1:0] {
      OUTER_HOLD = 2'd0,
      OUTER_INIT = 2'd1,
      OUTER_INC  = 2'd2
   } outer_op_type;

   typedef enum logic [1:0] {
      WR_NONE         = 2'd0,
      WR_NEW_AT_END   = 2'd1,
      WR_ENTRY_AT_PTR = 2'd2,
      WR_KEY_AT_PTR   = 2'd3
   } wr_sel_type;

   typedef enum logic [1:0] {
      FLAG_HOLD   = 2'd0,
      FLAG_APPEND = 2'd1,
      FLAG_SORTED = 2'd2,
      FLAG_DELETE = 2'd3
   } flag_op_type;

   typedef enum logic [1:0] {
      COUNT_HOLD = 2'd0,
      COUNT_INC  = 2'd1,
      COUNT_DEC  = 2'd2
   } count_op_type;

   // Controller to datapath.
   typedef struct packed {
      logic         capture;
      ptr_op_type   ptr_op;
      rd_src_type   rd_src;
      outer_op_type outer_op;
      wr_sel_type   wr_sel;
      flag_op_type  flag_op;
      count_op_type count_op;
      logic         key_load;
      logic         set_status;
      status_type   status_code;
      logic         set_found;
      logic         take_removed;
      logic         rsp_load;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      mode_type mode;
      logic     full;
      logic     empty;
      logic     idx_bad;
      logic     sort_trivial;
      logic     outer_last;
      logic     shift_go;
      logic     fit_hit;
      logic     ptr_last;
      logic     del_last;
   } dp_status_type;

endpackage

// ===== src/hlfa_req_if.sv =====
// Request channel of the hole list fit allocator: valid/ready plus the request fields.
// Depends on hlfa_pkg for the field widths.
`timescale 1ns / 1ps

interface hlfa_req_if import hlfa_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [MODE_W-1:0]     mode;
   logic [SIZE_W-1:0]     hole_size;
   logic [SIZE_W-1:0]     hole_offset;
   logic [SIZE_W-1:0]     request_size;
   logic [INDEX_IN_W-1:0] entry_index;

   modport source (
      output valid, mode, hole_size, hole_offset, request_size, entry_index,
      input  ready
   );

   modport sink (
      input  valid, mode, hole_size, hole_offset, request_size, entry_index,
      output ready
   );

endinterface

// ===== src/hlfa_rsp_if.sv =====
// Response channel of the hole list fit allocator: valid/ready plus the result fields.
// Depends on hlfa_pkg for the field widths.
`timescale 1ns / 1ps

interface hlfa_rsp_if import hlfa_pkg::*; ();

   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [FOUND_W-1:0]     found_index;
   logic [SIZE_W-1:0]      out_size;
   logic [SIZE_W-1:0]      out_offset;
   logic [COUNT_OUT_W-1:0] hole_count;

   modport source (
      output valid, status, found_index, out_size, out_offset, hole_count,
      input  ready
   );

   modport sink (
      input  valid, status, found_index, out_size, out_offset, hole_count,
      output ready
   );

endinterface

// ===== src/hlfa_csr.sv =====
// Register port of the hole list fit allocator: holds the fit policy register.
// Depends on hlfa_pkg for the register map and policy codes.
`timescale 1ns / 1ps

module hlfa_csr import hlfa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output policy_type            fit_policy
);

   policy_type  policy_ff;
   policy_type  policy_in;
   reg_idx_type reg_sel;
   logic        wr_access;

   // Word select and write strobe in the access phase.
   assign reg_sel   = paddr[CSR_ADDR_W-1:2];
   assign wr_access = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      policy_in = policy_ff;
      if (wr_access && (reg_sel == REG_FIT_POLICY)) begin
         policy_in = policy_type'(pwdata[POLICY_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_FIRST;
      end else begin
         policy_ff <= policy_in;
      end
   end

   // Read back; unmapped words read as zero.
   assign prdata     = (reg_sel == REG_FIT_POLICY) ? CSR_DATA_W'(policy_ff) : '0;
   assign fit_policy = policy_ff;

endmodule

// ===== src/hlfa_dp.sv =====
// Datapath of the hole list fit allocator: hole table memory, counters, key and result registers.
// Depends on hlfa_pkg; driven by the command struct from hlfa_ctrl.
`timescale 1ns / 1ps
`include "hole_list_fit_allocator_macros.svh"

module hlfa_dp import hlfa_pkg::*; #(
   parameter int TABLE_DEPTH = HLFA_TABLE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   input  policy_type             fit_policy,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [SIZE_W-1:0]      req_hole_size,
   input  logic [SIZE_W-1:0]      req_hole_offset,
   input  logic [SIZE_W-1:0]      req_request_size,
   input  logic [INDEX_IN_W-1:0]  req_entry_index,
   output dp_status_type          status,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [FOUND_W-1:0]     rsp_found_index,
   output logic [SIZE_W-1:0]      rsp_out_size,
   output logic [SIZE_W-1:0]      rsp_out_offset,
   output logic [COUNT_OUT_W-1:0] rsp_hole_count
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > INDEX_IN_W) ? CNT_W : INDEX_IN_W;

   // Hole table: one write and one registered read per cycle.
   entry_type hole_mem [TABLE_DEPTH];
   entry_type rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic             wr_en;

   // Control state.
   logic [CNT_W-1:0] count_ff, count_in;
   logic             asc_ok_ff, asc_ok_in;
   logic             desc_ok_ff, desc_ok_in;

   // Walk pointers and the key being placed.
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] outer_ff, outer_in;
   entry_type        key_ff, key_in;

   // Captured request.
   mode_type              mode_ff;
   entry_type             hole_ff;
   logic [SIZE_W-1:0]     need_ff;
   logic [INDEX_IN_W-1:0] index_ff;

   // Working result and response register.
   status_type          res_status_ff, res_status_in;
   logic [IDX_W-1:0]    res_found_ff, res_found_in;
   entry_type           res_removed_ff, res_removed_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [FOUND_W-1:0]     rsp_found_ff;
   entry_type              rsp_removed_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;

   logic sorted_for_policy;
   logic size_gt, size_lt, size_eq, offset_gt, offset_lt;
   logic goes_after;

   // The table is known to be in this policy's order already.
   assign sorted_for_policy = ((fit_policy == POLICY_BEST) && asc_ok_ff) ||
                              ((fit_policy == POLICY_WORST) && desc_ok_ff);

   // Entry at ptr-1 must stand after the key in the active sort order.
   assign size_gt   = rd_data_ff.hole_size > key_ff.hole_size;
   assign size_lt   = rd_data_ff.hole_size < key_ff.hole_size;
   assign size_eq   = rd_data_ff.hole_size == key_ff.hole_size;
   assign offset_gt = rd_data_ff.hole_offset > key_ff.hole_offset;
   assign offset_lt = rd_data_ff.hole_offset < key_ff.hole_offset;
   assign goes_after = (fit_policy == POLICY_BEST) ? (size_gt || (size_eq && offset_gt))
                                                   : (size_lt || (size_eq && offset_lt));

   // Status back to the controller.
   always_comb begin
      status.mode         = mode_ff;
      status.full         = count_ff == CNT_W'(TABLE_DEPTH);
      status.empty        = count_ff == '0;
      status.idx_bad      = CMP_W'(index_ff) >= CMP_W'(count_ff);
      status.sort_trivial = count_ff <= CNT_W'(1);
      status.outer_last   = (CNT_W'(outer_ff) + CNT_W'(1)) == count_ff;
      status.shift_go     = (ptr_ff != '0) && goes_after;
      status.fit_hit      = rd_data_ff.hole_size >= need_ff;
      status.ptr_last     = (CNT_W'(ptr_ff) + CNT_W'(1)) == count_ff;
      status.del_last     = ((CNT_W + 1)'(ptr_ff) + (CNT_W + 1)'(2)) == (CNT_W + 1)'(count_ff);
   end

   // Walk pointer.
   always_comb begin
      case (cmd.ptr_op)
         PTR_HOLD:  ptr_in = ptr_ff;
         PTR_ZERO:  ptr_in = '0;
         PTR_INDEX: ptr_in = IDX_W'(index_ff);
         PTR_OUTER: ptr_in = outer_ff;
         PTR_INC:   ptr_in = ptr_ff + IDX_W'(1);
         PTR_DEC:   ptr_in = ptr_ff - IDX_W'(1);
         default:   ptr_in = ptr_ff;
      endcase
   end

   // Outer sort position: only the new tail when the rest is already ordered.
   always_comb begin
      case (cmd.outer_op)
         OUTER_HOLD: outer_in = outer_ff;
         OUTER_INIT: outer_in = sorted_for_policy ? IDX_W'(count_ff - CNT_W'(1)) : IDX_W'(1);
         OUTER_INC:  outer_in = outer_ff + IDX_W'(1);
         default:    outer_in = outer_ff;
      endcase
   end

   // Read address follows the next pointer values, so the registered data is ready when used.
   always_comb begin
      case (cmd.rd_src)
         RD_PTR:    rd_addr = ptr_in;
         RD_PTR_M1: rd_addr = ptr_in - IDX_W'(1);
         RD_PTR_P1: rd_addr = ptr_in + IDX_W'(1);
         RD_OUTER:  rd_addr = outer_in;
         default:   rd_addr = ptr_in;
      endcase
   end

   // Write port selection.
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = ptr_ff;
      wr_data = rd_data_ff;
      case (cmd.wr_sel)
         WR_NONE: begin
            wr_en = 1'b0;
         end
         WR_NEW_AT_END: begin
            wr_addr = IDX_W'(count_ff);
            wr_data = hole_ff;
         end
         WR_ENTRY_AT_PTR: begin
            wr_data = rd_data_ff;
         end
         WR_KEY_AT_PTR: begin
            wr_data = key_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hole_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= hole_mem[rd_addr];
   end

   // Entry count.
   always_comb begin
      case (cmd.count_op)
         COUNT_HOLD: count_in = count_ff;
         COUNT_INC:  count_in = count_ff + CNT_W'(1);
         COUNT_DEC:  count_in = count_ff - CNT_W'(1);
         default:    count_in = count_ff;
      endcase
   end

   // Order flags; a table of at most one entry is in both orders.
   always_comb begin
      asc_ok_in  = asc_ok_ff;
      desc_ok_in = desc_ok_ff;
      case (cmd.flag_op)
         FLAG_HOLD: begin
            asc_ok_in  = asc_ok_ff;
         end
         FLAG_APPEND: begin
            asc_ok_in  = count_ff == '0;
            desc_ok_in = count_ff == '0;
         end
         FLAG_SORTED: begin
            asc_ok_in  = (fit_policy == POLICY_BEST) || (count_ff <= CNT_W'(1));
            desc_ok_in = (fit_policy == POLICY_WORST) || (count_ff <= CNT_W'(1));
         end
         FLAG_DELETE: begin
            asc_ok_in  = asc_ok_ff || (count_ff <= CNT_W'(2));
            desc_ok_in = desc_ok_ff || (count_ff <= CNT_W'(2));
         end
         default: begin
            asc_ok_in  = asc_ok_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         asc_ok_ff  <= 1'b1;
         desc_ok_ff <= 1'b1;
      end else begin
         count_ff   <= count_in;
         asc_ok_ff  <= asc_ok_in;
         desc_ok_ff <= desc_ok_in;
      end
   end

   // Working result of the current request.
   assign key_in = cmd.key_load ? rd_data_ff : key_ff;

   always_comb begin
      res_status_in  = res_status_ff;
      res_found_in   = res_found_ff;
      res_removed_in = res_removed_ff;
      if (cmd.capture) begin
         res_status_in  = STATUS_OK;
         res_found_in   = '0;
         res_removed_in = '0;
      end
      if (cmd.set_status) begin
         res_status_in = cmd.status_code;
      end
      if (cmd.set_found) begin
         res_found_in = ptr_ff;
      end
      if (cmd.take_removed) begin
         res_removed_in = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      outer_ff       <= outer_in;
      key_ff         <= key_in;
      res_status_ff  <= res_status_in;
      res_found_ff   <= res_found_in;
      res_removed_ff <= res_removed_in;
      if (cmd.capture) begin
         mode_ff             <= mode_type'(req_mode);
         hole_ff.hole_size   <= req_hole_size;
         hole_ff.hole_offset <= req_hole_offset;
         need_ff             <= req_request_size;
         index_ff            <= req_entry_index;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_found_ff   <= FOUND_W'(res_found_ff);
         rsp_removed_ff <= res_removed_ff;
         rsp_count_ff   <= COUNT_OUT_W'(count_ff);
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_out_size    = rsp_removed_ff.hole_size;
   assign rsp_out_offset  = rsp_removed_ff.hole_offset;
   assign rsp_hole_count  = rsp_count_ff;

   // Checks on table bookkeeping.
   `HLFA_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(TABLE_DEPTH), "entry count above depth")
   `HLFA_ASSERT_IMP(a_append_room, cmd.wr_sel == WR_NEW_AT_END, count_ff < CNT_W'(TABLE_DEPTH), "append into a full table")
   `HLFA_ASSERT_IMP(a_key_slot, cmd.wr_sel == WR_KEY_AT_PTR, ptr_ff <= outer_ff, "key placed above its source slot")

endmodule

// ===== src/hlfa_ctrl.sv =====
// Controller of the hole list fit allocator: sequences add, find, peek and delete.
// Depends on hlfa_pkg; drives hlfa_dp through the command struct.
`timescale 1ns / 1ps
`include "hole_list_fit_allocator_macros.svh"

module hlfa_ctrl import hlfa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  policy_type    fit_policy,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [10:0] {
      S_IDLE      = 11'b000_0000_0001,
      S_DISPATCH  = 11'b000_0000_0010,
      S_APPEND    = 11'b000_0000_0100,
      S_SORT_INIT = 11'b000_0000_1000,
      S_KEY       = 11'b000_0001_0000,
      S_SHIFT     = 11'b000_0010_0000,
      S_FIND      = 11'b000_0100_0000,
      S_PEEK      = 11'b000_1000_0000,
      S_DEL_READ  = 11'b001_0000_0000,
      S_DEL_SHIFT = 11'b010_0000_0000,
      S_FINISH    = 11'b100_0000_0000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and datapath commands.
   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.status_code  = STATUS_OK;
      req_ready        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.mode)
               MODE_ADD: begin
                  if (fit_policy == POLICY_NONE) begin
                     state_in = S_FINISH;
                  end else if (status.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_FULL;
                     state_in        = S_FINISH;
                  end else begin
                     state_in = S_APPEND;
                  end
               end
               MODE_FIND: begin
                  if (status.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_NO_FIT;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.ptr_op = PTR_ZERO;
                     cmd.rd_src = RD_PTR;
                     state_in   = S_FIND;
                  end
               end
               MODE_PEEK: begin
                  cmd.ptr_op = PTR_ZERO;
                  cmd.rd_src = RD_PTR;
                  state_in   = S_PEEK;
               end
               MODE_DELETE: begin
                  if (status.idx_bad) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_BAD_INDEX;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.ptr_op = PTR_INDEX;
                     cmd.rd_src = RD_PTR;
                     state_in   = S_DEL_READ;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_APPEND: begin
            cmd.wr_sel   = WR_NEW_AT_END;
            cmd.count_op = COUNT_INC;
            if (fit_policy == POLICY_FIRST) begin
               cmd.flag_op = FLAG_APPEND;
               state_in    = S_FINISH;
            end else begin
               state_in = S_SORT_INIT;
            end
         end
         S_SORT_INIT: begin
            if (status.sort_trivial) begin
               cmd.flag_op = FLAG_SORTED;
               state_in    = S_FINISH;
            end else begin
               cmd.outer_op = OUTER_INIT;
               cmd.rd_src   = RD_OUTER;
               state_in     = S_KEY;
            end
         end
         S_KEY: begin
            // Take the entry to place and start comparing downward.
            cmd.key_load = 1'b1;
            cmd.ptr_op   = PTR_OUTER;
            cmd.rd_src   = RD_PTR_M1;
            state_in     = S_SHIFT;
         end
         S_SHIFT: begin
            if (status.shift_go) begin
               cmd.wr_sel = WR_ENTRY_AT_PTR;
               cmd.ptr_op = PTR_DEC;
               cmd.rd_src = RD_PTR_M1;
            end else begin
               cmd.wr_sel = WR_KEY_AT_PTR;
               if (status.outer_last) begin
                  cmd.flag_op = FLAG_SORTED;
                  state_in    = S_FINISH;
               end else begin
                  cmd.outer_op = OUTER_INC;
                  cmd.rd_src   = RD_OUTER;
                  state_in     = S_KEY;
               end
            end
         end
         S_FIND: begin
            if (status.fit_hit) begin
               cmd.set_found = 1'b1;
               state_in      = S_FINISH;
            end else if (status.ptr_last) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_NO_FIT;
               state_in        = S_FINISH;
            end else begin
               cmd.ptr_op = PTR_INC;
               cmd.rd_src = RD_PTR;
            end
         end
         S_PEEK: begin
            if (status.empty || !status.fit_hit) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_NO_FIT;
            end
            state_in = S_FINISH;
         end
         S_DEL_READ: begin
            cmd.take_removed = 1'b1;
            if (status.ptr_last) begin
               cmd.count_op = COUNT_DEC;
               cmd.flag_op  = FLAG_DELETE;
               state_in     = S_FINISH;
            end else begin
               cmd.rd_src = RD_PTR_P1;
               state_in   = S_DEL_SHIFT;
            end
         end
         S_DEL_SHIFT: begin
            // Move the next entry down over the gap.
            cmd.wr_sel = WR_ENTRY_AT_PTR;
            cmd.ptr_op = PTR_INC;
            if (status.del_last) begin
               cmd.count_op = COUNT_DEC;
               cmd.flag_op  = FLAG_DELETE;
               state_in     = S_FINISH;
            end else begin
               cmd.rd_src = RD_PTR_P1;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response valid flag beside the datapath's response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Sequencing checks.
   `HLFA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready right after accepting a request")
   `HLFA_ASSERT_IMP(a_load_needs_room, cmd.rsp_load, out_free, "response overwritten before it was taken")
   `HLFA_ASSERT_IMP(a_valid_from_finish, $rose(rsp_valid_ff), $past(state_ff) == S_FINISH, "response raised outside finish")

endmodule

// ===== src/hole_list_fit_allocator.sv =====
// A table of free holes (size, offset) kept under first-fit, best-fit or worst-fit placement.
// One request is worked at a time in a controller and a datapath with one table memory
// (one read and one write port), so the time a request takes is set by how many entries
// the request walks through that port, one per cycle. A first-fit add, a refused or ignored
// add and a peek do not depend on the table's contents; a find grows with the index it stops
// at (an empty table is refused without a walk), a delete with the number of entries above
// the removed one (a bad index is refused without a walk), and a best-fit or worst-fit add
// into a table already in that order with the number of entries the new hole moves past.
// The first sorted add after entries were appended under another policy re-sorts the whole
// table by insertion. The response sits in an output register, so the next request is
// accepted while it waits.
// Depends on hlfa_pkg, the channel interfaces, hlfa_csr, hlfa_dp and hlfa_ctrl.
`timescale 1ns / 1ps

module hole_list_fit_allocator import hlfa_pkg::*; #(
   parameter int TABLE_DEPTH = HLFA_TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   hlfa_req_if.sink              req,
   hlfa_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   policy_type    fit_policy;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;

   // Policy register.
   hlfa_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .fit_policy (fit_policy)
   );

   // Sequencer.
   hlfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp.ready),
      .fit_policy (fit_policy),
      .status     (status),
      .cmd        (cmd)
   );

   // Table and result datapath.
   hlfa_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .fit_policy       (fit_policy),
      .req_mode         (req.mode),
      .req_hole_size    (req.hole_size),
      .req_hole_offset  (req.hole_offset),
      .req_request_size (req.request_size),
      .req_entry_index  (req.entry_index),
      .status           (status),
      .rsp_status       (rsp.status),
      .rsp_found_index  (rsp.found_index),
      .rsp_out_size     (rsp.out_size),
      .rsp_out_offset   (rsp.out_offset),
      .rsp_hole_count   (rsp.hole_count)
   );

   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for the hole list fit allocator: directed and random request
// traffic, a scoreboard that mirrors the hole table, and APB-style policy writes.
// Depends on hlfa_pkg, hlfa_req_if, hlfa_rsp_if and hole_list_fit_allocator.
`timescale 1ns / 1ps

module tb_top;
   import hlfa_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int DEPTH        = HLFA_TABLE_DEPTH;
   localparam int QUIET_LIMIT  = 20000;
   localparam int MAX_REPORTS  = 10;
   localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

   typedef struct packed {
      mode_type                mode;
      logic [SIZE_W-1:0]       hole_size;
      logic [SIZE_W-1:0]       hole_offset;
      logic [SIZE_W-1:0]       request_size;
      logic [INDEX_IN_W-1:0]   entry_index;
   } hole_request_type;

   typedef struct packed {
      status_type              status;
      logic [FOUND_W-1:0]      found_index;
      logic [SIZE_W-1:0]       out_size;
      logic [SIZE_W-1:0]       out_offset;
      logic [COUNT_OUT_W-1:0]  hole_count;
   } hole_response_type;

   // Mirror of the hole table plus the queue of responses it predicts.
   class hole_table_tracker;
      logic [SIZE_W-1:0] sizes [DEPTH];
      logic [SIZE_W-1:0] offsets [DEPTH];
      int unsigned       count;
      policy_type        policy;
      hole_response_type expected_q [$];
      int                mismatches;
      int                checked;
      int                peak_count;
      int                mode_seen [4];
      int                status_seen [4];

      function new();
         count = 0;
         policy = POLICY_FIRST;
         mismatches = 0;
         checked = 0;
         peak_count = 0;
         foreach (sizes[i]) begin
            sizes[i] = '0;
            offsets[i] = '0;
         end
         foreach (mode_seen[i]) begin
            mode_seen[i] = 0;
            status_seen[i] = 0;
         end
      endfunction

      function void report(string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, what);
      endfunction

      // Apply one accepted request to the mirror and queue the response it must produce.
      function void note_request(hole_request_type r);
         hole_response_type e;
         logic [SIZE_W-1:0] s;
         logic [SIZE_W-1:0] o;
         int                i;
         int                j;
         bit                shifting;
         bit                hit;
         e = '0;
         e.status = STATUS_OK;
         case (r.mode)
            MODE_ADD: begin
               if (policy != POLICY_NONE) begin
                  if (count >= DEPTH) begin
                     e.status = STATUS_FULL;
                  end else begin
                     sizes[count] = r.hole_size;
                     offsets[count] = r.hole_offset;
                     count++;
                     // Sorted policies re-order the whole table by insertion.
                     if (policy != POLICY_FIRST) begin
                        for (i = 1; i < count; i++) begin
                           s = sizes[i];
                           o = offsets[i];
                           j = i;
                           shifting = 1'b1;
                           while (j > 0 && shifting) begin
                              if (policy == POLICY_BEST)
                                 shifting = sizes[j-1] > s || (sizes[j-1] == s && offsets[j-1] > o);
                              else
                                 shifting = sizes[j-1] < s || (sizes[j-1] == s && offsets[j-1] < o);
                              if (shifting) begin
                                 sizes[j] = sizes[j-1];
                                 offsets[j] = offsets[j-1];
                                 j--;
                              end
                           end
                           sizes[j] = s;
                           offsets[j] = o;
                        end
                     end
                  end
               end
            end
            MODE_FIND: begin
               hit = 1'b0;
               for (i = 0; i < count; i++) begin
                  if (!hit && sizes[i] >= r.request_size) begin
                     hit = 1'b1;
                     e.found_index = FOUND_W'(i);
                  end
               end
               if (!hit) e.status = STATUS_NO_FIT;
            end
            MODE_PEEK: begin
               if (!(count > 0 && sizes[0] >= r.request_size)) e.status = STATUS_NO_FIT;
            end
            default: begin
               if (r.entry_index >= count) begin
                  e.status = STATUS_BAD_INDEX;
               end else begin
                  e.out_size = sizes[r.entry_index];
                  e.out_offset = offsets[r.entry_index];
                  for (i = int'(r.entry_index); i + 1 < count; i++) begin
                     sizes[i] = sizes[i+1];
                     offsets[i] = offsets[i+1];
                  end
                  count--;
               end
            end
         endcase
         e.hole_count = COUNT_OUT_W'(count);
         if (count > peak_count) peak_count = count;
         mode_seen[r.mode]++;
         status_seen[e.status]++;
         expected_q.push_back(e);
      endfunction

      // Compare one accepted response with the oldest prediction.
      function void check_response(hole_response_type got);
         hole_response_type e;
         if (expected_q.size() == 0) begin
            report($sformatf("response with nothing outstanding: status %0d count %0d",
                             got.status, got.hole_count));
         end else begin
            e = expected_q.pop_front();
            checked++;
            if (got.status !== e.status || got.found_index !== e.found_index ||
                got.out_size !== e.out_size || got.out_offset !== e.out_offset ||
                got.hole_count !== e.hole_count)
               report($sformatf({"response %0d: expected status %0d index %0d size %h ",
                                 "offset %h count %0d, got status %0d index %0d size %h ",
                                 "offset %h count %0d"},
                                checked, e.status, e.found_index, e.out_size, e.out_offset,
                                e.hole_count, got.status, got.found_index, got.out_size,
                                got.out_offset, got.hole_count));
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   hlfa_req_if req_chan ();
   hlfa_rsp_if rsp_chan ();

   hole_table_tracker tracker;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_request;
   int hold_left;
   int quiet_cycles;
   int fill_target;

   hole_list_fit_allocator dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Receiver: random back-pressure, or a long hold-off when one is asked for.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Every accepted response is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         tracker.check_response('{status:      status_type'(rsp_chan.status),
                                  found_index: rsp_chan.found_index,
                                  out_size:    rsp_chan.out_size,
                                  out_offset:  rsp_chan.out_offset,
                                  hole_count:  rsp_chan.hole_count});
   end

   // Watchdog: give up when no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (psel && penable && pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles, %0d responses outstanding",
                     quiet_cycles, tracker.expected_q.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   function automatic hole_request_type pack_request(mode_type m, logic [SIZE_W-1:0] hs,
                                                     logic [SIZE_W-1:0] ho,
                                                     logic [SIZE_W-1:0] rs,
                                                     int unsigned idx);
      hole_request_type r;
      r.mode = m;
      r.hole_size = hs;
      r.hole_offset = ho;
      r.request_size = rs;
      r.entry_index = INDEX_IN_W'(idx);
      return r;
   endfunction

   // Random request steered by the current fill target and the mirrored table contents.
   function automatic hole_request_type make_request();
      hole_request_type r;
      int unsigned      cnt;
      int unsigned      pick;
      cnt = tracker.count;
      r = pack_request(MODE_FIND, $urandom, $urandom, $urandom, $urandom);
      pick = $urandom_range(99);
      if (cnt < fill_target) begin
         if (pick < 85) r.mode = MODE_ADD;
         else if (pick < 92) r.mode = MODE_FIND;
         else if (pick < 96) r.mode = MODE_PEEK;
         else r.mode = MODE_DELETE;
      end else if (cnt > fill_target) begin
         if (pick < 60) r.mode = MODE_DELETE;
         else if (pick < 70) r.mode = MODE_ADD;
         else if (pick < 88) r.mode = MODE_FIND;
         else r.mode = MODE_PEEK;
      end else begin
         r.mode = mode_type'(pick % 4);
      end
      case (r.mode)
         MODE_ADD: begin
            // Small values give ties on size and offset; extremes hit the sort boundaries.
            case ($urandom_range(7))
               0, 1: begin
                  r.hole_size = $urandom_range(15);
                  r.hole_offset = $urandom_range(15);
               end
               2: begin
                  r.hole_size = $urandom_range(1) ? SIZE_MAX : '0;
                  r.hole_offset = $urandom_range(1) ? SIZE_MAX : '0;
               end
               3: r.hole_size = $urandom_range(15);
               default: ;
            endcase
         end
         MODE_FIND, MODE_PEEK: begin
            case ($urandom_range(6))
               0, 1: if (cnt > 0)
                  r.request_size = tracker.sizes[$urandom_range(cnt - 1)] + $urandom_range(1);
               2: if (cnt > 0) r.request_size = tracker.sizes[0] + $urandom_range(1);
               3: r.request_size = '0;
               4: r.request_size = SIZE_MAX;
               5: r.request_size = $urandom_range(20);
               default: ;
            endcase
         end
         default: begin
            if (cnt > 0 && pick % 10 < 8) r.entry_index = INDEX_IN_W'($urandom_range(cnt - 1));
            else if (pick % 10 == 8 && cnt < DEPTH) r.entry_index = INDEX_IN_W'(cnt);
         end
      endcase
      return r;
   endfunction

   // Offer one request, with random idle cycles first; returns at the falling edge.
   task automatic send_request(input hole_request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= r.mode;
      req_chan.hole_size <= r.hole_size;
      req_chan.hole_offset <= r.hole_offset;
      req_chan.request_size <= r.request_size;
      req_chan.entry_index <= r.entry_index;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      tracker.note_request(r);
      @(negedge clock);
   endtask

   // Stop offering requests and wait until every predicted response has come back.
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      while (tracker.expected_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Write the fit policy register once the block is idle, then read it back.
   task automatic set_fit_policy(input policy_type p);
      drain_responses();
      paddr <= {REG_FIT_POLICY, 2'b00};
      pwdata <= CSR_DATA_W'(p);
      pwrite <= 1'b1;
      psel <= 1'b1;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      tracker.policy = p;
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== CSR_DATA_W'(p))
         tracker.report($sformatf("fit policy read back %h, expected %h", prdata, p));
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      int         stage;
      int         k;
      int         i;
      int         block_items;
      policy_type p;

      tracker = new();
      clock = 1'b0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_ADD;
      req_chan.hole_size = '0;
      req_chan.hole_offset = '0;
      req_chan.request_size = '0;
      req_chan.entry_index = '0;
      rsp_chan.ready = 1'b0;
      send_idle_pct = 34;
      recv_idle_pct = 50;
      hold_request = 0;
      hold_left = 0;
      quiet_cycles = 0;
      fill_target = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty table, extreme values, each mode and each policy code.
      set_fit_policy(POLICY_FIRST);
      send_request(pack_request(MODE_PEEK, 0, 0, 0, 0));
      send_request(pack_request(MODE_FIND, 0, 0, 0, 0));
      send_request(pack_request(MODE_DELETE, 0, 0, 0, 0));
      send_request(pack_request(MODE_DELETE, 0, 0, 0, 63));
      send_request(pack_request(MODE_ADD, 0, 0, 0, 0));
      send_request(pack_request(MODE_ADD, SIZE_MAX, SIZE_MAX, 0, 0));
      send_request(pack_request(MODE_ADD, 5, 100, 0, 0));
      send_request(pack_request(MODE_ADD, 5, 50, 0, 0));
      send_request(pack_request(MODE_FIND, 0, 0, 0, 0));
      send_request(pack_request(MODE_FIND, 0, 0, SIZE_MAX, 0));
      send_request(pack_request(MODE_FIND, 0, 0, 6, 0));
      send_request(pack_request(MODE_PEEK, 0, 0, 0, 0));
      send_request(pack_request(MODE_PEEK, 0, 0, 1, 0));
      // The first best-fit add re-sorts the entries appended under first-fit.
      set_fit_policy(POLICY_BEST);
      send_request(pack_request(MODE_ADD, 5, 75, 0, 0));
      send_request(pack_request(MODE_FIND, 0, 0, 5, 0));
      send_request(pack_request(MODE_DELETE, 0, 0, 0, 4));
      send_request(pack_request(MODE_DELETE, 0, 0, 0, 4));
      // The unused policy code makes adds do nothing.
      set_fit_policy(POLICY_NONE);
      send_request(pack_request(MODE_ADD, 9, 9, 0, 0));
      send_request(pack_request(MODE_PEEK, 0, 0, 0, 0));
      set_fit_policy(POLICY_WORST);
      send_request(pack_request(MODE_ADD, 5, 60, 0, 0));
      send_request(pack_request(MODE_DELETE, 0, 0, 0, 0));
      send_request(pack_request(MODE_PEEK, 0, 0, SIZE_MAX, 0));
      send_request(pack_request(MODE_FIND, 0, 0, 0, 0));
      send_request(pack_request(MODE_DELETE, 0, 0, 0, 2));

      // Random: three idling profiles, each cycling through every policy code.
      for (stage = 0; stage < 3; stage++) begin
         send_idle_pct = (stage == 0) ? 34 : (stage == 1) ? 50 : 0;
         recv_idle_pct = (stage == 0) ? 50 : (stage == 1) ? 34 : 0;
         for (k = 0; k < 4; k++) begin
            p = policy_type'((stage + k) % 4);
            set_fit_policy(p);
            block_items = (p == POLICY_NONE) ? 30 : 70;
            for (i = 0; i < block_items; i++) begin
               if (i % 35 == 0) begin
                  case ($urandom_range(3))
                     0: fill_target = 0;
                     1: fill_target = $urandom_range(1, 8);
                     2: fill_target = $urandom_range(20, 48);
                     default: fill_target = DEPTH;
                  endcase
               end
               // Long receiver hold-off so the output register fills and input stalls.
               if (stage == 0 && k == 1 && i == 20) hold_request = 400;
               // Sender pause until the block has answered everything.
               if (stage == 1 && k == 2 && i == 15) drain_responses();
               send_request(make_request());
            end
         end
      end

      drain_responses();
      repeat (100) @(posedge clock);

      $display("Sent %0d requests (add %0d, find %0d, peek %0d, delete %0d) over all policy codes;",
               tracker.checked, tracker.mode_seen[MODE_ADD], tracker.mode_seen[MODE_FIND],
               tracker.mode_seen[MODE_PEEK], tracker.mode_seen[MODE_DELETE]);
      $display("statuses ok %0d, no fit %0d, full %0d, bad index %0d; peak fill %0d of %0d.",
               tracker.status_seen[STATUS_OK], tracker.status_seen[STATUS_NO_FIT],
               tracker.status_seen[STATUS_FULL], tracker.status_seen[STATUS_BAD_INDEX],
               tracker.peak_count, DEPTH);
      if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d responses missing", tracker.mismatches,
                  tracker.expected_q.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/hlfa_pkg.sv
src/hlfa_req_if.sv
src/hlfa_rsp_if.sv
src/hlfa_csr.sv
src/hlfa_dp.sv
src/hlfa_ctrl.sv
src/hole_list_fit_allocator.sv
verif/tb_top.sv
